// ----- rtl/core/pfmb_pkg.sv -----
// pfmb_pkg: shared types, constants and decode functions for the fuse map builder
// no dependencies; imported by pld_fuse_map_builder and tb_top
package pfmb_pkg;

	localparam int FUSE_TOTAL = 5892;
	localparam int ROW_BITS   = 44;
	localparam int ROW_COUNT  = (FUSE_TOTAL + ROW_BITS - 1) / ROW_BITS;
	localparam int ROW_AW     = $clog2(ROW_COUNT);
	localparam int COL_W      = $clog2(ROW_BITS);
	localparam int WORD_BITS  = 32;

	// word_address * 32 / 44 == (word_address * RECIP) >> RECIP_SHIFT for all 8-bit addresses
	localparam int RECIP       = 1490;
	localparam int RECIP_SHIFT = 11;

	localparam logic [4:0] PIN_OUT_LOW  = 5'd14;
	localparam logic [4:0] PIN_OUT_HIGH = 5'd23;

	localparam logic [1:0] KIND_CLEAR   = 2'd0;
	localparam logic [1:0] KIND_OPEN    = 2'd1;
	localparam logic [1:0] KIND_LITERAL = 2'd2;
	localparam logic [1:0] KIND_READ    = 2'd3;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_BAD_OUT  = 2'd1;
	localparam logic [1:0] STATUS_TOO_MANY = 2'd2;
	localparam logic [1:0] STATUS_BAD_IN   = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [4:0] output_pin;
		logic [3:0] term_index;
		logic [4:0] input_pin;
		logic       inverted;
		logic       registered;
		logic [7:0] word_address;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] read_word;
	} rsp_item_t;

	typedef struct packed {
		logic             ok;
		logic [COL_W-1:0] col;
	} col_sel_t;

	// product terms owned by each output cell
	function automatic logic [4:0] cell_terms(input logic [4:0] pin);
		logic [4:0] t;
		case (pin)
			5'd14: t = 5'd8;
			5'd15: t = 5'd10;
			5'd16: t = 5'd12;
			5'd17: t = 5'd14;
			5'd18: t = 5'd16;
			5'd19: t = 5'd16;
			5'd20: t = 5'd14;
			5'd21: t = 5'd12;
			5'd22: t = 5'd10;
			5'd23: t = 5'd8;
			default: t = 5'd0;
		endcase
		return t;
	endfunction

	// first row of each output cell, cells laid out from pin 23 downward
	function automatic logic [ROW_AW-1:0] cell_base(input logic [4:0] pin);
		logic [ROW_AW-1:0] b;
		case (pin)
			5'd23: b = ROW_AW'(1);
			5'd22: b = ROW_AW'(10);
			5'd21: b = ROW_AW'(21);
			5'd20: b = ROW_AW'(34);
			5'd19: b = ROW_AW'(49);
			5'd18: b = ROW_AW'(66);
			5'd17: b = ROW_AW'(83);
			5'd16: b = ROW_AW'(98);
			5'd15: b = ROW_AW'(111);
			5'd14: b = ROW_AW'(122);
			default: b = '0;
		endcase
		return b;
	endfunction

	function automatic col_sel_t lit_column(input logic [4:0] pin, input logic inv,
			input logic regd);
		col_sel_t   s;
		logic [4:0] d;
		s = '0;
		d = '0;
		case (pin) inside
			[5'd1:5'd11]: begin
				d = pin - 5'd1;
				s.ok = 1'b1;
				s.col = {d[3:0], 1'b0, inv};
			end
			5'd13: begin
				s.ok = 1'b1;
				s.col = COL_W'(42) + COL_W'(inv);
			end
			[5'd14:5'd23]: begin
				d = pin - PIN_OUT_LOW;
				s.ok = 1'b1;
				s.col = COL_W'(38) - {d[3:0], 2'b00} + COL_W'(inv ^ regd);
			end
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

// ----- rtl/core/pld_fuse_map_builder.sv -----
// pld_fuse_map_builder: fuse map of a 22V10-style device kept in a row memory
// depends on pfmb_pkg (types, codes, row and column decode)
//
//   channel | signals                      | direction | payload
//   cmd     | cmd_valid, cmd_stall, cmd    | in        | cmd_item_t
//   rsp     | rsp_valid, rsp_stall, rsp    | out       | rsp_item_t
//
// each item is accepted, then completed: the accept cycle reads up to two rows of the
// 134 x 44 row memory, the completing cycle modifies and writes back at most one row and
// loads the response register. completion waits while a response is stalled.
// after reset the map is all zero with row 0 all ones, held by per-row valid bits;
// a clear item drops all valid bits at once, so no clearing pass is needed.
module pld_fuse_map_builder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  pfmb_pkg::cmd_item_t   cmd,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output pfmb_pkg::rsp_item_t   rsp
);
	import pfmb_pkg::*;

	localparam logic [ROW_BITS-1:0] ROW_ONES = '1;

	logic [ROW_BITS-1:0] mem [0:ROW_COUNT-1];
	logic [ROW_COUNT-1:0] vld_q;
	logic                 busy_q;

	logic                 accept;
	logic                 done;
	logic [4:0]           terms;
	logic                 pin_ok;
	logic                 term_ok;
	col_sel_t             lit;
	logic [1:0]           status_d;
	logic [ROW_AW-1:0]    row_d;
	logic [18:0]          prod;
	logic [7:0]           wrow;
	logic [12:0]          fuse_start;
	logic [12:0]          row_fuse;
	logic [COL_W-1:0]     wcol;
	logic [8:0]           addr_a;
	logic [8:0]           addr_b;
	logic                 in_a;
	logic                 in_b;
	logic [ROW_AW-1:0]    idx_a;
	logic [ROW_AW-1:0]    idx_b;

	logic [1:0]           kind_s1;
	logic [1:0]           status_s1;
	logic [ROW_AW-1:0]    row_s1;
	logic [COL_W-1:0]     col_s1;
	logic                 in_a_s1;
	logic                 in_b_s1;
	logic                 row0_a_s1;
	logic                 vld_a_s1;
	logic                 vld_b_s1;
	logic [ROW_BITS-1:0]  rd_a_s1;
	logic [ROW_BITS-1:0]  rd_b_s1;

	logic [ROW_BITS-1:0]  eff_a;
	logic [ROW_BITS-1:0]  eff_b;
	logic [2*ROW_BITS-1:0] pair_sh;
	logic [ROW_BITS-1:0]  clr_mask;
	logic [ROW_BITS-1:0]  wr_data;
	logic                 wr_en;
	logic [31:0]          word;

	assign cmd_stall = busy_q;
	assign accept    = cmd_valid && !busy_q;
	assign done      = busy_q && (!rsp_valid || !rsp_stall);

	// item decode
	always_comb begin
		terms   = cell_terms(cmd.output_pin);
		pin_ok  = (cmd.output_pin >= PIN_OUT_LOW) && (cmd.output_pin <= PIN_OUT_HIGH);
		term_ok = {1'b0, cmd.term_index} < terms;
		lit     = lit_column(cmd.input_pin, cmd.inverted, cmd.registered);
		status_d = STATUS_OK;
		if (cmd.kind == KIND_OPEN || cmd.kind == KIND_LITERAL) begin
			if (!pin_ok)
				status_d = STATUS_BAD_OUT;
			else if (!term_ok)
				status_d = STATUS_TOO_MANY;
			else if (cmd.kind == KIND_LITERAL && !lit.ok)
				status_d = STATUS_BAD_IN;
		end
		row_d = cell_base(cmd.output_pin) + ROW_AW'(cmd.term_index);

		// word read: start row by reciprocal multiply, column by remainder
		prod       = 19'(cmd.word_address) * 19'(RECIP);
		wrow       = prod[18:RECIP_SHIFT];
		fuse_start = {cmd.word_address, 5'b00000};
		row_fuse   = 13'({wrow, 5'b00000}) + 13'({wrow, 3'b000}) + 13'({wrow, 2'b00});
		wcol       = COL_W'(fuse_start - row_fuse);

		addr_a = (cmd.kind == KIND_READ) ? {1'b0, wrow} : 9'(row_d);
		addr_b = {1'b0, wrow} + 9'd1;
		in_a   = addr_a < 9'(ROW_COUNT);
		in_b   = addr_b < 9'(ROW_COUNT);
		idx_a  = in_a ? addr_a[ROW_AW-1:0] : '0;
		idx_b  = in_b ? addr_b[ROW_AW-1:0] : '0;
	end

	// rows that were never written read as their reset value
	always_comb begin
		eff_a = '0;
		if (in_a_s1)
			eff_a = vld_a_s1 ? rd_a_s1 : (row0_a_s1 ? ROW_ONES : '0);
		eff_b = '0;
		if (in_b_s1)
			eff_b = vld_b_s1 ? rd_b_s1 : '0;
		pair_sh  = {eff_b, eff_a} >> col_s1;
		word     = (kind_s1 == KIND_READ) ? pair_sh[WORD_BITS-1:0] : '0;
		clr_mask = ROW_BITS'(1) << col_s1;
		wr_data  = (kind_s1 == KIND_OPEN) ? ROW_ONES : (eff_a & ~clr_mask);
		wr_en    = done && (status_s1 == STATUS_OK)
			&& (kind_s1 == KIND_OPEN || kind_s1 == KIND_LITERAL);
	end

	// row memory, read on accept, written when the item completes
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_a_s1 <= mem[idx_a];
			rd_b_s1 <= mem[idx_b];
		end
		if (wr_en)
			mem[row_s1] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= cmd.kind;
			status_s1 <= status_d;
			row_s1    <= row_d;
			col_s1    <= (cmd.kind == KIND_READ) ? wcol : lit.col;
			in_a_s1   <= in_a;
			in_b_s1   <= in_b;
			row0_a_s1 <= (idx_a == '0);
			vld_a_s1  <= vld_q[idx_a];
			vld_b_s1  <= vld_q[idx_b];
		end
		if (done)
			rsp <= '{status: status_s1, read_word: word};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			rsp_valid <= 1'b0;
			vld_q     <= '0;
		end else begin
			if (accept)
				busy_q <= 1'b1;
			else if (done)
				busy_q <= 1'b0;

			if (done)
				rsp_valid <= 1'b1;
			else if (!rsp_stall)
				rsp_valid <= 1'b0;

			if (done && kind_s1 == KIND_CLEAR)
				vld_q <= '0;
			else if (wr_en)
				vld_q[row_s1] <= 1'b1;
		end
	end

endmodule

// ----- bench/tb_top.sv -----
// tb_top: self-checking bench for pld_fuse_map_builder, directed table then random items
// depends on pfmb_pkg for the item structs, kind and status codes and map sizes
`timescale 1ns / 1ps

module tb_top;
	import pfmb_pkg::*;

	typedef struct {
		cmd_item_t c;
		bit        typed;
		rsp_item_t want;
	} dir_row_t;

	typedef enum int {STALL_OFF, STALL_LIGHT, STALL_HEAVY, STALL_EVERY3} stall_mode_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	cmd_item_t cmd;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_item_t rsp;

	logic [ROW_BITS-1:0] fuse_image [ROW_COUNT];
	rsp_item_t           pending_rsp [$];
	dir_row_t            dir_table [$];

	int  n_errors = 0;
	int  n_checked = 0;
	int  n_kind [4] = '{0, 0, 0, 0};
	int  n_status [4] = '{0, 0, 0, 0};
	int  burst_left = 0;
	int  long_holds = 0;
	bit  hold_req = 1'b0;

	pld_fuse_map_builder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("FAIL");
		$finish;
	end

	// ---------------- fuse map predictor ----------------

	function automatic void clear_image();
		for (int r = 0; r < ROW_COUNT; r++)
			fuse_image[r] = '0;
		fuse_image[0] = '1;
	endfunction

	// cells grow by two terms toward the middle pins 18 and 19
	function automatic int term_limit(input logic [4:0] pin);
		if (pin < PIN_OUT_LOW || pin > PIN_OUT_HIGH)
			return 0;
		if (pin <= 18)
			return 8 + 2 * (pin - PIN_OUT_LOW);
		return 8 + 2 * (PIN_OUT_HIGH - pin);
	endfunction

	function automatic int lit_col(input logic [4:0] pin, input logic inv, input logic regd);
		if (pin >= 1 && pin <= 11)
			return 4 * (pin - 1) + inv;
		if (pin == 13)
			return 42 + inv;
		if (pin >= PIN_OUT_LOW && pin <= PIN_OUT_HIGH)
			return 38 - 4 * (pin - PIN_OUT_LOW) + (inv ^ regd);
		return -1;
	endfunction

	function automatic rsp_item_t apply_item(input cmd_item_t c);
		rsp_item_t r;
		int        row;
		int        col;
		int        f;
		r = '0;
		case (c.kind)
			KIND_CLEAR: clear_image();
			KIND_OPEN, KIND_LITERAL: begin
				if (c.output_pin < PIN_OUT_LOW || c.output_pin > PIN_OUT_HIGH) begin
					r.status = STATUS_BAD_OUT;
				end else if (c.term_index >= term_limit(c.output_pin)) begin
					r.status = STATUS_TOO_MANY;
				end else begin
					// cells are stacked from pin 23 down, after the reset row
					row = 1;
					for (int p = PIN_OUT_HIGH; p > c.output_pin; p--)
						row += term_limit(p) + 1;
					row += c.term_index;
					if (c.kind == KIND_OPEN) begin
						fuse_image[row] = '1;
					end else begin
						col = lit_col(c.input_pin, c.inverted, c.registered);
						if (col < 0)
							r.status = STATUS_BAD_IN;
						else
							fuse_image[row][col] = 1'b0;
					end
				end
			end
			default: begin
				for (int b = 0; b < WORD_BITS; b++) begin
					f = c.word_address * WORD_BITS + b;
					if (f < FUSE_TOTAL)
						r.read_word[b] = fuse_image[f / ROW_BITS][f % ROW_BITS];
				end
			end
		endcase
		return r;
	endfunction

	// ---------------- stimulus ----------------

	task automatic add_row(input logic [1:0] kind, input int opin, input int term,
			input int ipin, input bit inv, input bit regd, input int addr,
			input bit typed, input logic [1:0] status, input logic [31:0] word);
		dir_row_t d;
		d.c = '0;
		d.c.kind = kind;
		d.c.output_pin = 5'(opin);
		d.c.term_index = 4'(term);
		d.c.input_pin = 5'(ipin);
		d.c.inverted = inv;
		d.c.registered = regd;
		d.c.word_address = 8'(addr);
		d.typed = typed;
		d.want.status = status;
		d.want.read_word = word;
		dir_table.push_back(d);
	endtask

	function automatic cmd_item_t rand_cmd();
		cmd_item_t c;
		int        pick;
		int        idx;
		c = cmd_item_t'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 10)
			return c;
		if (pick < 12) begin
			c.kind = KIND_CLEAR;
		end else if (pick < 37) begin
			c.kind = KIND_READ;
			if ($urandom_range(0, 9) == 0)
				c.word_address = 8'($urandom);
			else
				c.word_address = 8'($urandom_range(0, 184));
		end else begin
			c.kind = (pick < 60) ? KIND_OPEN : KIND_LITERAL;
			c.output_pin = 5'($urandom_range(PIN_OUT_LOW, PIN_OUT_HIGH));
			c.term_index = 4'($urandom_range(0, term_limit(c.output_pin) - 1));
			// legal literal pins: 1..11, 13, 14..23
			idx = $urandom_range(0, 21);
			if (idx < 11)
				c.input_pin = 5'(idx + 1);
			else if (idx == 11)
				c.input_pin = 5'd13;
			else
				c.input_pin = 5'(idx + 2);
		end
		return c;
	endfunction

	// offers one item from a falling edge, returns at the falling edge after it is taken
	task automatic send_item(input cmd_item_t c, input bit typed, input rsp_item_t want);
		rsp_item_t got;
		cmd <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		got = apply_item(c);
		if (typed)
			got = want;
		pending_rsp.push_back(got);
		n_kind[c.kind]++;
		n_status[got.status]++;
		@(negedge clk);
	endtask

	task automatic pace();
		if (burst_left == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 20);
		end else begin
			burst_left--;
		end
	endtask

	initial begin : stimulus
		dir_row_t d;
		cmd_valid = 1'b0;
		cmd = '0;
		arst_n = 1'b0;
		clear_image();

		// reads right after reset: row 0 all ones, rest zero
		add_row(KIND_READ, 0, 0, 0, 0, 0, 0, 1, STATUS_OK, 32'hFFFF_FFFF);
		add_row(KIND_READ, 0, 0, 0, 0, 0, 1, 1, STATUS_OK, 32'h0000_0FFF);
		add_row(KIND_READ, 0, 0, 0, 0, 0, 184, 1, STATUS_OK, 32'h0);
		add_row(KIND_READ, 31, 15, 31, 1, 1, 255, 1, STATUS_OK, 32'h0);
		// error codes, output pin checked before term, term before input pin
		add_row(KIND_OPEN, 0, 0, 1, 0, 0, 0, 1, STATUS_BAD_OUT, 32'h0);
		add_row(KIND_LITERAL, 31, 15, 0, 1, 1, 255, 1, STATUS_BAD_OUT, 32'h0);
		add_row(KIND_OPEN, 23, 8, 1, 0, 0, 0, 1, STATUS_TOO_MANY, 32'h0);
		add_row(KIND_LITERAL, 14, 15, 12, 0, 0, 0, 1, STATUS_TOO_MANY, 32'h0);
		add_row(KIND_LITERAL, 23, 0, 0, 0, 0, 0, 1, STATUS_BAD_IN, 32'h0);
		add_row(KIND_LITERAL, 23, 0, 12, 0, 0, 0, 1, STATUS_BAD_IN, 32'h0);
		add_row(KIND_LITERAL, 23, 0, 31, 1, 1, 0, 1, STATUS_BAD_IN, 32'h0);
		// first term of pin 23, column 0 cleared
		add_row(KIND_OPEN, 23, 0, 0, 0, 0, 0, 1, STATUS_OK, 32'h0);
		add_row(KIND_LITERAL, 23, 0, 1, 0, 0, 0, 1, STATUS_OK, 32'h0);
		add_row(KIND_READ, 0, 0, 0, 0, 0, 1, 1, STATUS_OK, 32'hFFFF_EFFF);
		add_row(KIND_LITERAL, 23, 0, 13, 1, 0, 0, 0, STATUS_OK, 32'h0);
		add_row(KIND_LITERAL, 23, 0, 23, 1, 1, 0, 0, STATUS_OK, 32'h0);
		add_row(KIND_LITERAL, 23, 0, 14, 1, 0, 0, 0, STATUS_OK, 32'h0);
		add_row(KIND_OPEN, 14, 7, 0, 0, 0, 0, 0, STATUS_OK, 32'h0);
		add_row(KIND_LITERAL, 14, 7, 11, 1, 0, 0, 0, STATUS_OK, 32'h0);
		add_row(KIND_OPEN, 18, 15, 0, 0, 0, 0, 0, STATUS_OK, 32'h0);
		// literal on a row never opened still clears its fuse
		add_row(KIND_LITERAL, 19, 3, 5, 0, 1, 0, 0, STATUS_OK, 32'h0);
		add_row(KIND_READ, 0, 0, 0, 0, 0, 2, 0, STATUS_OK, 32'h0);
		add_row(KIND_READ, 0, 0, 0, 0, 0, 176, 0, STATUS_OK, 32'h0);
		add_row(KIND_READ, 0, 0, 0, 0, 0, 183, 0, STATUS_OK, 32'h0);
		add_row(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 1, STATUS_OK, 32'h0);
		add_row(KIND_READ, 0, 0, 0, 0, 0, 0, 1, STATUS_OK, 32'hFFFF_FFFF);
		add_row(KIND_READ, 0, 0, 0, 0, 0, 2, 1, STATUS_OK, 32'h0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_table[i]) begin
			d = dir_table[i];
			send_item(d.c, d.typed, d.want);
			pace();
		end

		for (int i = 0; i < 1000; i++) begin
			if (i == 300)
				hold_req = 1'b1;
			send_item(rand_cmd(), 1'b0, '0);
			pace();
		end
		cmd_valid <= 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("items: %0d clear, %0d open, %0d literal, %0d read; %0d long receiver hold(s)",
			n_kind[KIND_CLEAR], n_kind[KIND_OPEN], n_kind[KIND_LITERAL], n_kind[KIND_READ],
			long_holds);
		$display("results checked: %0d; status ok %0d, bad out %0d, too many %0d, bad in %0d",
			n_checked, n_status[STATUS_OK], n_status[STATUS_BAD_OUT],
			n_status[STATUS_TOO_MANY], n_status[STATUS_BAD_IN]);
		if (n_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// ---------------- receiver ----------------

	initial begin : rsp_pacer
		stall_mode_t mode;
		int          left;
		rsp_stall = 1'b0;
		mode = STALL_OFF;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				// long hold-off so the block backs up into its input
				hold_req = 1'b0;
				long_holds++;
				rsp_stall <= 1'b1;
				repeat (400) @(negedge clk);
			end
			if (left == 0) begin
				mode = stall_mode_t'($urandom_range(0, 3));
				left = $urandom_range(8, 80);
			end
			left--;
			case (mode)
				STALL_OFF:   rsp_stall <= 1'b0;
				STALL_LIGHT: rsp_stall <= ($urandom_range(0, 99) < 30);
				STALL_HEAVY: rsp_stall <= ($urandom_range(0, 99) < 70);
				default:     rsp_stall <= (left % 3 == 0);
			endcase
		end
	end

	always @(posedge clk) begin : rsp_check
		rsp_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			n_checked++;
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected item, got status %0d word %h", $time,
					rsp.status, rsp.read_word);
				n_errors++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status) begin
					$display("%0t: status mismatch, expected %0d, got %0d", $time,
						want.status, rsp.status);
					n_errors++;
				end
				if (rsp.read_word !== want.read_word) begin
					$display("%0t: read_word mismatch, expected %h, got %h", $time,
						want.read_word, rsp.read_word);
					n_errors++;
				end
			end
		end
	end

endmodule
